>>> design/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared types and constants of the two-level page table manager: command
// and status codes, and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package tlpt_pkg;

	localparam int IDX_W             = 10;
	localparam int DIR_ENTRIES       = 1 << IDX_W;
	localparam int ENTRIES_PER_TABLE = 1 << IDX_W;
	localparam int ADDR_W            = 32;
	localparam int OFS_W             = 12;
	localparam int DIR_LSB           = 22;
	localparam int TBL_LSB           = 12;

	typedef enum logic [1:0] {
		OP_MAP   = 2'd0,
		OP_UNMAP = 2'd1,
		OP_XLATE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOT_MAPPED = 2'd1,
		ST_NO_SLOT    = 2'd2
	} st_t;

	typedef enum logic [1:0] {
		RS_OK     = 2'd0,
		RS_NOMAP  = 2'd1,
		RS_NOSLOT = 2'd2,
		RS_XLATE  = 2'd3
	} res_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     dir_clr;
		logic     dir_rd;
		logic     dir_alloc;
		logic     load_slot;
		logic     tbl_clr;
		logic     tbl_wr;
		logic     tbl_rd;
		logic     set_res;
		res_sel_t res_sel;
		logic     load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic dir_present;
		logic have_free;
		logic sweep_done;
		logic out_free;
	} dp_status_t;

endpackage

>>> design/tlpt_dpath.sv
// ----------------------------------------------------------------------------
// tlpt_dpath
// Datapath: input holding registers, directory and table memories, sweep
// counter, bump allocator, result and output registers.
// ----------------------------------------------------------------------------
module tlpt_dpath #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tlpt_pkg::ctrl_cmd_t    cmd,
	output tlpt_pkg::dp_status_t   sts,
	input  logic [1:0]             command,
	input  logic [31:0]            virt_addr,
	input  logic [31:0]            phys_addr,
	input  logic [11:0]            page_flags,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic [1:0]             status,
	output logic [31:0]            result_addr
);
	import tlpt_pkg::*;

	localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int FREE_W    = $clog2(TABLE_SLOTS + 1);
	localparam int DIR_W     = SLOT_W + 1;
	localparam int TBL_DEPTH = TABLE_SLOTS * ENTRIES_PER_TABLE;
	localparam int TBL_AW    = $clog2(TBL_DEPTH);

	logic [1:0]          cmd_q;
	logic [ADDR_W-1:0]   va_q;
	logic [ADDR_W-1:0]   pa_q;
	logic [OFS_W-1:0]    flags_q;
	logic [IDX_W-1:0]    sweep_q;
	logic [FREE_W-1:0]   free_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [DIR_W-1:0]    dir_rd_q;
	logic [ADDR_W-1:0]   tbl_rd_q;
	st_t                 res_st_q;
	logic [ADDR_W-1:0]   res_addr_q;
	logic                out_valid_q;
	logic [1:0]          out_st_q;
	logic [ADDR_W-1:0]   out_addr_q;

	logic [DIR_W-1:0]    dir_mem [DIR_ENTRIES];
	logic [ADDR_W-1:0]   tbl_mem [TBL_DEPTH];

	logic [IDX_W-1:0]    dir_idx;
	logic [IDX_W-1:0]    tbl_idx;
	logic [IDX_W-1:0]    dir_waddr;
	logic [DIR_W-1:0]    dir_wdata;
	logic [SLOT_W+IDX_W-1:0] tbl_full;
	logic [TBL_AW-1:0]   tbl_addr;
	logic [ADDR_W-1:0]   tbl_wdata;
	logic                out_xfer;
	st_t                 res_st_d;
	logic [ADDR_W-1:0]   res_addr_d;

	assign dir_idx   = va_q[DIR_LSB +: IDX_W];
	assign tbl_idx   = va_q[TBL_LSB +: IDX_W];
	assign dir_waddr = cmd.dir_clr ? sweep_q : dir_idx;
	assign dir_wdata = cmd.dir_clr ? '0 : {1'b1, free_q[SLOT_W-1:0]};
	assign tbl_full  = {slot_q, (cmd.tbl_clr ? sweep_q : tbl_idx)};
	assign tbl_addr  = tbl_full[TBL_AW-1:0];
	assign out_xfer  = out_valid_q && !out_stall;

	always_comb begin
		tbl_wdata = '0;
		if (!cmd.tbl_clr && op_t'(cmd_q) == OP_MAP) begin
			tbl_wdata = {pa_q[ADDR_W-1:OFS_W], flags_q[OFS_W-1:1], 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q   <= command;
			va_q    <= virt_addr;
			pa_q    <= phys_addr;
			flags_q <= page_flags;
		end
		if (cmd.dir_clr || cmd.dir_alloc) begin
			dir_mem[dir_waddr] <= dir_wdata;
		end
		if (cmd.dir_rd) begin
			dir_rd_q <= dir_mem[dir_idx];
		end
		if (cmd.tbl_clr || cmd.tbl_wr) begin
			tbl_mem[tbl_addr] <= tbl_wdata;
		end
		if (cmd.tbl_rd) begin
			tbl_rd_q <= tbl_mem[tbl_addr];
		end
		if (cmd.load_slot) begin
			slot_q <= cmd.dir_alloc ? free_q[SLOT_W-1:0] : dir_rd_q[SLOT_W-1:0];
		end
		if (cmd.set_res) begin
			res_st_q   <= res_st_d;
			res_addr_q <= res_addr_d;
		end
		if (cmd.load_out) begin
			out_st_q   <= res_st_q;
			out_addr_q <= res_addr_q;
		end
	end

	always_comb begin
		res_st_d   = ST_NOT_MAPPED;
		res_addr_d = '0;
		case (cmd.res_sel)
			RS_OK:     res_st_d = ST_OK;
			RS_NOMAP:  res_st_d = ST_NOT_MAPPED;
			RS_NOSLOT: res_st_d = ST_NO_SLOT;
			RS_XLATE: begin
				if (tbl_rd_q[0]) begin
					res_st_d   = ST_OK;
					res_addr_d = {tbl_rd_q[ADDR_W-1:OFS_W], va_q[OFS_W-1:0]};
				end
			end
			default:   res_st_d = ST_NOT_MAPPED;
		endcase
	end

	// sweep wraps back to zero at the end of every pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			free_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.dir_clr || cmd.tbl_clr) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (cmd.dir_alloc) begin
				free_q <= free_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.op          = op_t'(cmd_q);
		sts.dir_present = dir_rd_q[SLOT_W];
		sts.have_free   = free_q < FREE_W'(TABLE_SLOTS);
		sts.sweep_done  = &sweep_q;
		sts.out_free    = !out_valid_q || !out_stall;
	end

	assign out_valid   = out_valid_q;
	assign status      = out_st_q;
	assign result_addr = out_addr_q;

endmodule

>>> design/tlpt_ctrl.sv
// ----------------------------------------------------------------------------
// tlpt_ctrl
// Controller: sequences the reset clearing pass, directory lookup, table
// allocation and clear, table access and result hand-off.
// ----------------------------------------------------------------------------
module tlpt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  tlpt_pkg::dp_status_t sts,
	output tlpt_pkg::ctrl_cmd_t  cmd
);
	import tlpt_pkg::*;

	typedef enum logic [8:0] {
		S_DCLR = 9'b000000001,
		S_IDLE = 9'b000000010,
		S_DIR  = 9'b000000100,
		S_DEC  = 9'b000001000,
		S_TCLR = 9'b000010000,
		S_TWR  = 9'b000100000,
		S_TRD  = 9'b001000000,
		S_TCHK = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_DCLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_DCLR: begin
				cmd.dir_clr = 1'b1;
				if (sts.sweep_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) state_d = S_DIR;
			end
			S_DIR: begin
				cmd.dir_rd = 1'b1;
				state_d    = S_DEC;
			end
			S_DEC: begin
				case (sts.op)
					OP_MAP: begin
						if (sts.dir_present) begin
							cmd.load_slot = 1'b1;
							state_d       = S_TWR;
						end else if (sts.have_free) begin
							cmd.load_slot = 1'b1;
							cmd.dir_alloc = 1'b1;
							state_d       = S_TCLR;
						end else begin
							cmd.set_res = 1'b1;
							cmd.res_sel = RS_NOSLOT;
							state_d     = S_FIN;
						end
					end
					OP_UNMAP, OP_XLATE: begin
						if (sts.dir_present) begin
							cmd.load_slot = 1'b1;
							state_d       = (sts.op == OP_UNMAP) ? S_TWR : S_TRD;
						end else begin
							cmd.set_res = 1'b1;
							cmd.res_sel = RS_NOMAP;
							state_d     = S_FIN;
						end
					end
					default: begin
						cmd.set_res = 1'b1;
						cmd.res_sel = RS_NOMAP;
						state_d     = S_FIN;
					end
				endcase
			end
			S_TCLR: begin
				cmd.tbl_clr = 1'b1;
				if (sts.sweep_done) state_d = S_TWR;
			end
			S_TWR: begin
				cmd.tbl_wr  = 1'b1;
				cmd.set_res = 1'b1;
				cmd.res_sel = RS_OK;
				state_d     = S_FIN;
			end
			S_TRD: begin
				cmd.tbl_rd = 1'b1;
				state_d    = S_TCHK;
			end
			S_TCHK: begin
				cmd.set_res = 1'b1;
				cmd.res_sel = RS_XLATE;
				state_d     = S_FIN;
			end
			S_FIN: begin
				// hold the result until the output register is free
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> design/two_level_page_table_manager_top.sv
// ----------------------------------------------------------------------------
// two_level_page_table_manager_top
// Two-level page table: map, unmap and translate commands, one result each.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 1024 directory
// entries and stalls its input until that is done. Items are then handled
// one at a time, paced by the single-port directory and table memories: a
// command is accepted, reads its directory entry and is decoded. One with
// no directory entry (or an unknown code) ends there; map and unmap write
// the table entry, translate reads and checks it. A map that allocates a
// new table first clears it one entry a cycle. The result sits in an
// output register, so the next item is taken while the previous result
// still waits for transfer; tables are allocated in order, never returned.
module two_level_page_table_manager_top #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] virt_addr,
	input  logic [31:0] phys_addr,
	input  logic [11:0] page_flags,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] result_addr
);
	import tlpt_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	tlpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tlpt_dpath #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.command     (command),
		.virt_addr   (virt_addr),
		.phys_addr   (phys_addr),
		.page_flags  (page_flags),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.result_addr (result_addr)
	);

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while an item is still in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || !out_stall))
		else $error("result loaded over a pending output transfer");

	a_alloc_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dir_alloc |-> (sts.have_free && !sts.dir_present))
		else $error("table allocated with no free slot or an existing table");
`endif

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-level page table manager. Sends map, unmap,
// translate and unknown commands through the valid/stall input, predicts each
// result against an in-bench copy of the directory and table pool, and checks
// every result transfer in order. Covers empty tables, extreme addresses and
// flags, overwrite and unmap, random traffic over a small set of hot regions,
// back-pressure, and running out of table slots.
// ----------------------------------------------------------------------------
module testbench;
	import tlpt_pkg::*;

	localparam int SLOTS      = 16;
	localparam int POS_W      = $clog2(SLOTS * ENTRIES_PER_TABLE);
	localparam int WD_LIMIT   = 8000;
	localparam int HOLD_LEN   = 300;
	localparam int MAX_REPORT = 10;

	typedef struct {
		op_t         op;
		logic [31:0] va;
		st_t         status;
		logic [31:0] addr;
	} page_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [31:0] virt_addr;
	logic [31:0] phys_addr;
	logic [11:0] page_flags;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [31:0] result_addr;

	// Predicted page table state
	bit                pde_valid [DIR_ENTRIES];
	int unsigned       pde_slot  [DIR_ENTRIES];
	logic [31:0]       pte_mem   [SLOTS * ENTRIES_PER_TABLE];
	int unsigned       tables_used;

	page_result_t      pending_results [$];
	int unsigned       errors;
	int unsigned       mismatches;
	int unsigned       items_sent;
	int unsigned       ops_sent [4];
	int unsigned       status_seen [4];
	int unsigned       slot_full_maps;

	bit                tx_idle_on;
	bit                rx_idle_on;
	bit                rx_hold_req;
	logic [9:0]        hot_dir [20];
	logic [9:0]        hot_idx [8];

	two_level_page_table_manager_top #(
		.TABLE_SLOTS(SLOTS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.virt_addr   (virt_addr),
		.phys_addr   (phys_addr),
		.page_flags  (page_flags),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.result_addr (result_addr)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic page_result_t walk_page_table(op_t op, logic [31:0] va,
			logic [31:0] pa, logic [11:0] fl);
		page_result_t     r;
		logic [9:0]       pd;
		logic [POS_W-1:0] pos;
		logic [31:0]      pte;
		pd       = va[31:22];
		r.op     = op;
		r.va     = va;
		r.status = ST_NOT_MAPPED;
		r.addr   = '0;
		pos      = POS_W'(pde_slot[pd] * ENTRIES_PER_TABLE + 32'(va[21:12]));
		case (op)
			OP_MAP: begin
				if (!pde_valid[pd] && tables_used < SLOTS) begin
					for (int i = 0; i < ENTRIES_PER_TABLE; i++)
						pte_mem[POS_W'(tables_used * ENTRIES_PER_TABLE + i)] = '0;
					pde_slot[pd]  = tables_used;
					pde_valid[pd] = 1'b1;
					tables_used++;
					pos = POS_W'(pde_slot[pd] * ENTRIES_PER_TABLE + 32'(va[21:12]));
				end
				if (pde_valid[pd]) begin
					pte_mem[pos] = {pa[31:12], fl | 12'h001};
					r.status     = ST_OK;
				end else begin
					r.status = ST_NO_SLOT;
				end
			end
			OP_UNMAP: begin
				if (pde_valid[pd]) begin
					pte_mem[pos] = '0;
					r.status     = ST_OK;
				end
			end
			OP_XLATE: begin
				if (pde_valid[pd]) begin
					pte = pte_mem[pos];
					if (pte[0]) begin
						r.addr   = {pte[31:12], va[11:0]};
						r.status = ST_OK;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Offer one command and hold it until the transfer; predict on acceptance
	task automatic send_item(op_t op, logic [31:0] va, logic [31:0] pa, logic [11:0] fl);
		page_result_t r;
		@(negedge clk);
		if (tx_idle_on && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid   <= 1'b1;
		command    <= op;
		virt_addr  <= va;
		phys_addr  <= pa;
		page_flags <= fl;
		do @(posedge clk); while (in_stall);
		r = walk_page_table(op, va, pa, fl);
		if (r.status == ST_NO_SLOT)
			slot_full_maps++;
		pending_results.push_back(r);
		items_sent++;
		ops_sent[op]++;
	endtask

	task automatic stop_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_for_drain();
		stop_input();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_va();
		logic [9:0] pd;
		logic [9:0] pt;
		if ($urandom_range(0, 99) < 8)
			return $urandom;
		pd = hot_dir[$urandom_range(0, 19)];
		pt = ($urandom_range(0, 99) < 85) ? hot_idx[$urandom_range(0, 7)]
				: 10'($urandom_range(0, 1023));
		return {pd, pt, 12'($urandom)};
	endfunction

	task automatic test_empty_tables();
		send_item(OP_XLATE, 32'h0000_0000, 32'h0, 12'h000);
		send_item(OP_UNMAP, 32'hFFFF_FFFF, 32'h0, 12'h000);
		send_item(OP_NONE,  32'h1234_5678, 32'hFFFF_FFFF, 12'hFFF);
		send_item(OP_XLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
	endtask

	task automatic test_map_translate();
		send_item(OP_MAP,   32'h0000_0000, 32'hFFFF_FFFF, 12'h000);
		send_item(OP_XLATE, 32'h0000_0FFF, 32'h0, 12'h000);
		send_item(OP_MAP,   32'hFFFF_FFFF, 32'h0000_0000, 12'hFFF);
		// frame zero: translate succeeds with an all-zero address
		send_item(OP_XLATE, 32'hFFFF_F000, 32'h0, 12'h000);
		// same table, entry never written since the clear
		send_item(OP_XLATE, 32'hFFC0_0000, 32'h0, 12'h000);
		// present bit clear in the flags: still forced on
		send_item(OP_MAP,   32'h0000_1ABC, 32'h8000_0123, 12'h0FE);
		send_item(OP_XLATE, 32'h0000_1000, 32'h0, 12'h000);
		send_item(OP_MAP,   32'h0000_1000, 32'h1234_5000, 12'h000);
		send_item(OP_XLATE, 32'h0000_1555, 32'h0, 12'h000);
		send_item(OP_NONE,  32'h0000_0000, 32'h0, 12'h000);
	endtask

	task automatic test_unmap();
		send_item(OP_UNMAP, 32'h0000_0123, 32'hFFFF_FFFF, 12'hFFF);
		send_item(OP_XLATE, 32'h0000_0000, 32'h0, 12'h000);
		// table present, entry already clear
		send_item(OP_UNMAP, 32'h0000_0000, 32'h0, 12'h000);
		send_item(OP_UNMAP, 32'h0040_0000, 32'h0, 12'h000);
		send_item(OP_XLATE, 32'h0000_1FFF, 32'h0, 12'h000);
	endtask

	task automatic test_random_traffic(int unsigned n_items);
		int unsigned first;
		int unsigned pick;
		bit          held;
		bit          paused;
		logic [31:0] va;
		first  = items_sent;
		held   = 1'b0;
		paused = 1'b0;
		hot_dir[0] = 10'd0;
		hot_dir[1] = 10'd1023;
		for (int i = 2; i < 20; i++)
			hot_dir[i] = 10'($urandom_range(0, 1023));
		hot_idx[0] = 10'd0;
		hot_idx[1] = 10'd1023;
		for (int i = 2; i < 8; i++)
			hot_idx[i] = 10'($urandom_range(0, 1023));
		while (items_sent - first < n_items) begin
			if (!tx_idle_on && items_sent - first >= 300) begin
				tx_idle_on = 1'b1;
				rx_idle_on = 1'b1;
			end
			if (!held && items_sent - first >= 500) begin
				rx_hold_req = 1'b1;
				held        = 1'b1;
			end
			if (!paused && items_sent - first >= 750) begin
				wait_for_drain();
				paused = 1'b1;
			end
			va   = pick_va();
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				send_item(OP_MAP, va, $urandom, 12'($urandom));
				send_item(OP_XLATE, {va[31:12], 12'($urandom)}, $urandom, 12'($urandom));
				if ($urandom_range(0, 2) == 0) begin
					send_item(OP_UNMAP, va, $urandom, 12'($urandom));
					send_item(OP_XLATE, va, $urandom, 12'($urandom));
				end
			end else if (pick < 72) begin
				send_item(OP_XLATE, va, $urandom, 12'($urandom));
			end else if (pick < 82) begin
				send_item(OP_UNMAP, va, $urandom, 12'($urandom));
			end else if (pick < 94) begin
				send_item(OP_MAP, va, $urandom, 12'($urandom));
			end else begin
				send_item(OP_NONE, va, $urandom, 12'($urandom));
			end
		end
	endtask

	task automatic test_slot_exhaustion();
		logic [9:0] pd;
		while (tables_used < SLOTS) begin
			do pd = 10'($urandom_range(0, 1023)); while (pde_valid[pd]);
			send_item(OP_MAP, {pd, 22'($urandom)}, $urandom, 12'($urandom));
		end
		do pd = 10'($urandom_range(0, 1023)); while (pde_valid[pd]);
		send_item(OP_MAP,   {pd, 22'h3F_FFFF}, 32'hFFFF_FFFF, 12'hFFF);
		send_item(OP_XLATE, {pd, 22'h3F_FFFF}, 32'h0, 12'h000);
		send_item(OP_UNMAP, {pd, 22'h00_0000}, 32'h0, 12'h000);
	endtask

	// Result side: random stall, plus one long hold-off counted here
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left   = HOLD_LEN;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= rx_idle_on && ($urandom_range(0, 99) < 11);
			end
		end
	end

	initial begin
		page_result_t exp;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (status inside {[0:3]})
					status_seen[status]++;
				if (pending_results.size() == 0) begin
					errors++;
					$display("result with nothing expected: status %0d addr %h",
						status, result_addr);
				end else begin
					exp = pending_results.pop_front();
					if (status !== exp.status || result_addr !== exp.addr) begin
						errors++;
						mismatches++;
						if (mismatches <= MAX_REPORT)
							$display("mismatch %s va %h: expected status %0d addr %h, got status %0d addr %h",
								exp.op.name(), exp.va, exp.status, exp.addr,
								status, result_addr);
					end
				end
			end
		end
	end

	// Watchdog: abort when no transfer happens on either side for too long
	initial begin
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WD_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results pending",
					quiet, pending_results.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		command     = OP_NONE;
		virt_addr   = '0;
		phys_addr   = '0;
		page_flags  = '0;
		tx_idle_on  = 1'b0;
		rx_idle_on  = 1'b0;
		rx_hold_req = 1'b0;
		tables_used = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_tables();
		test_map_translate();
		test_unmap();
		test_random_traffic(1000);
		test_slot_exhaustion();

		wait_for_drain();
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0) begin
			errors++;
			$display("%0d results never arrived", pending_results.size());
		end

		$display("Ran %0d commands (map %0d, unmap %0d, translate %0d, unknown %0d).",
			items_sent, ops_sent[OP_MAP], ops_sent[OP_UNMAP], ops_sent[OP_XLATE],
			ops_sent[OP_NONE]);
		$display("%0d tables allocated, %0d maps refused for lack of a slot, %0d mismatches.",
			tables_used, slot_full_maps, mismatches);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
